// ===== sv/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SPB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spb check failed");

// Check a property on every clock edge, reset included.
`define SPB_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("spb check failed during reset");

`endif

// ===== sv/spb_pkg.sv =====
package spb_pkg;

  localparam int unsigned PixW   = 16;
  localparam int unsigned ModeW  = 3;
  localparam int unsigned AlphaW = 6;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;

  // Full alpha weight
  localparam logic [AlphaW-1:0] AlphaMax = 6'd32;

  // Average masks after the half shift
  localparam logic [PixW-1:0] AvgMask565 = 16'h7BEF;
  localparam logic [PixW-1:0] AvgMask555 = 16'h3DEF;

  // RGB555 additive: mask clearing bits 15, 10 and 5, and the carry positions
  localparam logic [PixW-1:0] AddMask555  = 16'h7BDF;
  localparam logic [PixW-1:0] AddCarry555 = 16'h8420;

  typedef enum logic [ModeW-1:0] {
    MODE_COPY  = 3'd0,
    MODE_AVG   = 3'd1,
    MODE_ADD   = 3'd2,
    MODE_SUB   = 3'd3,
    MODE_ALPHA = 3'd4,
    MODE_KEEP5 = 3'd5,
    MODE_KEEP6 = 3'd6,
    MODE_KEEP7 = 3'd7
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLEND_MODE   = 2'd0,
    CFG_FORMAT_565   = 2'd1,
    CFG_ALPHA_WEIGHT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic              format_565;
    logic [AlphaW-1:0] alpha;
  } cfg_t;

endpackage

// ===== sv/spb_core.sv =====
module spb_core import spb_pkg::*; (
  input  cfg_t            cfg_i,
  input  logic [PixW-1:0] src_i,
  input  logic [PixW-1:0] dst_i,
  output logic [PixW-1:0] pixel_o
);

  logic            w565;
  // Channels, green widened to 6 bits for both layouts
  logic [4:0]      sb, db, sr, dr;
  logic [5:0]      sg, dg;
  logic [5:0]      add_b, add_r;
  logic [6:0]      add_g;
  logic [4:0]      sat_b, sat_r;
  logic [5:0]      sat_g;
  logic [5:0]      sub_b, sub_r;
  logic [6:0]      sub_g;
  logic [4:0]      dif_b, dif_r;
  logic [5:0]      dif_g;
  logic [5:0]      inv;
  logic [9:0]      al_b, al_r;
  logic [10:0]     al_g;
  logic [PixW-1:0] avg_mask, avg_pix;
  logic [PixW-1:0] v555, c555, add555;
  logic [PixW-1:0] add_pix, sub_pix, alpha_pix;
  logic [4:0]      alr, alb;
  logic [5:0]      alg;

  assign w565 = cfg_i.format_565;

  // Split both pixels into channels
  assign sb = src_i[4:0];
  assign db = dst_i[4:0];
  assign sg = w565 ? src_i[10:5]  : {1'b0, src_i[9:5]};
  assign dg = w565 ? dst_i[10:5]  : {1'b0, dst_i[9:5]};
  assign sr = w565 ? src_i[15:11] : src_i[14:10];
  assign dr = w565 ? dst_i[15:11] : dst_i[14:10];

  // Average by half shift
  assign avg_mask = w565 ? AvgMask565 : AvgMask555;
  assign avg_pix  = ((src_i >> 1) & avg_mask) + ((dst_i >> 1) & avg_mask);

  // Additive, RGB565: saturate each channel
  assign add_b = {1'b0, sb} + {1'b0, db};
  assign add_g = {1'b0, sg} + {1'b0, dg};
  assign add_r = {1'b0, sr} + {1'b0, dr};
  assign sat_b = add_b[5] ? 5'h1F : add_b[4:0];
  assign sat_g = add_g[6] ? 6'h3F : add_g[5:0];
  assign sat_r = add_r[5] ? 5'h1F : add_r[4:0];

  // Additive, RGB555: carry-spread trick over the packed word
  assign v555   = (src_i & AddMask555) + (dst_i & AddMask555);
  assign c555   = v555 & AddCarry555;
  assign add555 = v555 | (c555 - (c555 >> 5));

  assign add_pix = w565 ? {sat_r, sat_g, sat_b} : add555;

  // Subtractive: floor negative differences, and a one-step green in RGB565
  assign sub_b = {1'b0, db} - {1'b0, sb};
  assign sub_g = {1'b0, dg} - {1'b0, sg};
  assign sub_r = {1'b0, dr} - {1'b0, sr};
  assign dif_b = sub_b[5] ? 5'd0 : sub_b[4:0];
  assign dif_r = sub_r[5] ? 5'd0 : sub_r[4:0];
  assign dif_g = (sub_g[6] || (w565 && (sub_g[5:0] < 6'd2))) ? 6'd0 : sub_g[5:0];

  assign sub_pix = w565 ? {dif_r, dif_g, dif_b} : {1'b0, dif_r, dif_g[4:0], dif_b};

  // Alpha: destination weight alpha, source weight 32 minus alpha
  assign inv  = AlphaMax - cfg_i.alpha;
  assign al_b = {4'd0, inv} * {5'd0, sb} + {4'd0, cfg_i.alpha} * {5'd0, db};
  assign al_g = {5'd0, inv} * {5'd0, sg} + {5'd0, cfg_i.alpha} * {5'd0, dg};
  assign al_r = {4'd0, inv} * {5'd0, sr} + {4'd0, cfg_i.alpha} * {5'd0, dr};
  assign alb  = al_b[9:5];
  assign alg  = al_g[10:5];
  assign alr  = al_r[9:5];

  assign alpha_pix = w565 ? {alr, alg, alb} : {1'b0, alr, alg[4:0], alb};

  // Select by mode; a zero source is transparent
  always_comb begin
    if (src_i == '0) begin
      pixel_o = dst_i;
    end else begin
      case (cfg_i.mode)
        MODE_COPY:  pixel_o = src_i;
        MODE_AVG:   pixel_o = avg_pix;
        MODE_ADD:   pixel_o = add_pix;
        MODE_SUB:   pixel_o = sub_pix;
        MODE_ALPHA: pixel_o = alpha_pix;
        default:    pixel_o = dst_i;
      endcase
    end
  end

endmodule

// ===== sv/sprite_pixel_blend_565_555.sv =====
// Sprite pixel compositor, RGB565 or RGB555.
// Requests pass the input register, then the result register. Throughput: one
// pixel per cycle unless the output stalls; the compositing logic between the two
// registers sets the clock, and both advance together when the output is taken.
// Reset (rst_ni low, asynchronous): both stages empty, mode copy, RGB565, alpha 0.
module sprite_pixel_blend_565_555 import spb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*PixW-1:0]   s_axis_tdata,   // [15:0] src_color, [31:16] dst_pixel
  // Output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [PixW-1:0]     m_axis_tdata    // [15:0] out_pixel
);

  cfg_t            cfg_q, cfg_d;
  logic            in_vld_q, in_vld_d;
  logic [PixW-1:0] src_q, dst_q;
  logic            out_vld_q, out_vld_d;
  logic [PixW-1:0] pix_q, pix_d;
  logic            adv;
  logic            in_load;

  // Register writes; clamp alpha to full weight
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BLEND_MODE:   cfg_d.mode = mode_e'(cfg_data_i[ModeW-1:0]);
        CFG_FORMAT_565:   cfg_d.format_565 = cfg_data_i[0];
        CFG_ALPHA_WEIGHT: cfg_d.alpha = (cfg_data_i > AlphaMax) ? AlphaMax : cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: MODE_COPY, format_565: 1'b1, alpha: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Advance the input stage when the result stage is free or drains
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign in_load       = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = s_axis_tready ? s_axis_tvalid : in_vld_q;
  assign out_vld_d     = adv ? in_vld_q : out_vld_q;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      src_q <= s_axis_tdata[PixW-1:0];
      dst_q <= s_axis_tdata[2*PixW-1:PixW];
    end
  end

  spb_core u_core (
    .cfg_i   (cfg_q),
    .src_i   (src_q),
    .dst_i   (dst_q),
    .pixel_o (pix_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_vld_q) begin
      pix_q <= pix_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = pix_q;

endmodule

// ===== sv/spb_checker.sv =====
`include "assert_macros.svh"

module spb_checker import spb_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [PixW-1:0]     m_axis_tdata
);

  // Hold a stalled result
  `SPB_ASSERT(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))

  // Keep accepting while the output drains
  `SPB_ASSERT(a_ready_follows, clk_i, rst_ni, m_axis_tready |-> s_axis_tready)

  // Raise a result only for a request that passed through the input register
  `SPB_ASSERT(a_latency, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))

  // Show no result once reset has been seen at an edge
  `SPB_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule

bind sprite_pixel_blend_565_555 spb_checker u_spb_checker (.*);

// ===== test/tb_sprite_pixel_blend_565_555.sv =====
`timescale 1ns / 100ps

module tb_sprite_pixel_blend_565_555;
  import spb_pkg::*;

  localparam int unsigned PIPE_LATENCY  = 2;
  localparam int unsigned MAX_CYCLES    = 400000;
  localparam int unsigned RANDOM_PHASES = 22;
  localparam int unsigned PHASE_ITEMS   = 50;

  // Channel fields in place
  localparam logic [PixW-1:0] BLUE_MASK     = 16'h001F;
  localparam logic [PixW-1:0] GREEN565_MASK = 16'h07E0;
  localparam logic [PixW-1:0] RED565_MASK   = 16'hF800;
  localparam logic [PixW-1:0] GREEN555_MASK = 16'h03E0;
  localparam logic [PixW-1:0] RED555_MASK   = 16'h7C00;

  // Subtractive floors: a smaller difference gives zero; two steps for RGB565 green
  localparam int unsigned GREEN565_FLOOR = 64;
  localparam int unsigned RED565_FLOOR   = 2048;
  localparam int unsigned GREEN555_FLOOR = 31;
  localparam int unsigned RED555_FLOOR   = 1023;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [2*PixW-1:0]   s_axis_tdata  = '0;   // [15:0] src_color, [31:16] dst_pixel
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [PixW-1:0]     m_axis_tdata;         // [15:0] out_pixel

  // Shadow copy of the blend registers
  mode_e             cur_mode   = MODE_COPY;
  logic              cur_fmt565 = 1'b1;
  logic [AlphaW-1:0] cur_alpha  = '0;

  logic [PixW-1:0] expected_pixels[$];
  int unsigned     error_count = 0;
  int unsigned     cycle_count = 0;
  int unsigned     rx_hold     = 0;
  logic            tx_gaps_on  = 1'b1;
  logic            rx_stall_on = 1'b1;

  sprite_pixel_blend_565_555 i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Blend predictor

  function automatic logic [PixW-1:0] add_sat_565(input logic [PixW-1:0] src, dst);
    int unsigned lo, mid, hi;
    lo  = (src & BLUE_MASK) + (dst & BLUE_MASK);
    mid = (src & GREEN565_MASK) + (dst & GREEN565_MASK);
    hi  = (src & RED565_MASK) + (dst & RED565_MASK);
    if (lo > BLUE_MASK) lo = BLUE_MASK;
    if (mid > GREEN565_MASK) mid = GREEN565_MASK;
    if (hi > RED565_MASK) hi = RED565_MASK;
    return PixW'(lo + mid + hi);
  endfunction

  // Carries land on bits 15, 10 and 5; smear each one down over its channel
  function automatic logic [PixW-1:0] add_sat_555(input logic [PixW-1:0] src, dst);
    logic [PixW-1:0] sum, carry;
    sum   = (src & AddMask555) + (dst & AddMask555);
    carry = sum & AddCarry555;
    return sum | (carry - (carry >> 5));
  endfunction

  function automatic logic [PixW-1:0] sub_field(input logic [PixW-1:0] src, dst, mask,
                                                input int unsigned step_floor);
    int unsigned dv, sv;
    dv = dst & mask;
    sv = src & mask;
    if (dv < sv || dv - sv < step_floor) return '0;
    return PixW'(dv - sv);
  endfunction

  function automatic logic [PixW-1:0] alpha_field(input logic [PixW-1:0] src, dst, mask);
    int unsigned weight, mixed;
    weight = cur_alpha;
    mixed  = ((AlphaMax - weight) * (src & mask) + weight * (dst & mask)) >> 5;
    return PixW'(mixed) & mask;
  endfunction

  function automatic logic [PixW-1:0] composite_pixel(input logic [PixW-1:0] src, dst);
    logic [PixW-1:0] avg_mask;
    // Transparent source keeps the framebuffer in every mode
    if (src == '0) return dst;
    avg_mask = cur_fmt565 ? AvgMask565 : AvgMask555;
    case (cur_mode)
      MODE_COPY: return src;
      MODE_AVG:  return ((src >> 1) & avg_mask) + ((dst >> 1) & avg_mask);
      MODE_ADD:  return cur_fmt565 ? add_sat_565(src, dst) : add_sat_555(src, dst);
      MODE_SUB: begin
        if (cur_fmt565)
          return sub_field(src, dst, BLUE_MASK, 0)
               + sub_field(src, dst, GREEN565_MASK, GREEN565_FLOOR)
               + sub_field(src, dst, RED565_MASK, RED565_FLOOR);
        return sub_field(src, dst, BLUE_MASK, 0)
             + sub_field(src, dst, GREEN555_MASK, GREEN555_FLOOR)
             + sub_field(src, dst, RED555_MASK, RED555_FLOOR);
      end
      MODE_ALPHA: begin
        if (cur_fmt565)
          return alpha_field(src, dst, BLUE_MASK) + alpha_field(src, dst, GREEN565_MASK)
               + alpha_field(src, dst, RED565_MASK);
        return alpha_field(src, dst, BLUE_MASK) + alpha_field(src, dst, GREEN555_MASK)
             + alpha_field(src, dst, RED555_MASK);
      end
      default: return dst;
    endcase
  endfunction

  // Random helpers: mostly short gaps, a few long ones

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [PixW-1:0] pick_color();
    case ($urandom_range(0, 7))
      0:       return '1;
      1:       return '0;
      2:       return PixW'(1) << $urandom_range(0, PixW - 1);
      3:       return ~(PixW'(1) << $urandom_range(0, PixW - 1));
      default: return PixW'($urandom);
    endcase
  endfunction

  // Output side: stall at random while enabled
  always @(negedge clk_i) begin
    if (rx_hold != 0) begin
      rx_hold       <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
      rx_hold       <= pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest expected pixel
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("out_pixel: expected none, got %h", m_axis_tdata);
        error_count++;
      end else begin
        if (m_axis_tdata !== expected_pixels[0]) begin
          $error("out_pixel: expected %h, got %h", expected_pixels[0], m_axis_tdata);
          error_count++;
        end
        void'(expected_pixels.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Send one request; called and returns at a falling edge
  task automatic send_pixel(input logic [PixW-1:0] src, dst);
    int unsigned gap;
    s_axis_tdata  <= {dst, src};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(composite_pixel(src, dst));
    @(negedge clk_i);
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Hold off until every result is back and the pipeline is empty
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 2) @(negedge clk_i);
  endtask

  // Write one register; keep the write enable high when another write follows
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgDataW-1:0] data,
                           input logic last_write);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_BLEND_MODE:   cur_mode = mode_e'(data[ModeW-1:0]);
      CFG_FORMAT_565:   cur_fmt565 = data[0];
      CFG_ALPHA_WEIGHT: cur_alpha = (data > AlphaMax) ? AlphaMax : data;
      default: ;
    endcase
    @(negedge clk_i);
    if (last_write) cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [CfgDataW-1:0] mode_data, fmt_data, alpha_data);
    wait_for_results();
    write_reg(CFG_BLEND_MODE, mode_data, 1'b0);
    write_reg(CFG_FORMAT_565, fmt_data, 1'b0);
    write_reg(CFG_ALPHA_WEIGHT, alpha_data, 1'b1);
  endtask

  // Reset values: copy mode, RGB565
  task automatic test_reset_state();
    send_pixel(16'h1234, 16'hABCD);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000);
  endtask

  // Every mode, most of them in both formats, field extremes and the subtractive floors
  task automatic test_blend_modes();
    set_config(CfgDataW'(MODE_AVG), 6'd1, 6'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h0841, 16'hF7BE);
    set_config(CfgDataW'(MODE_ADD), 6'd1, 6'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h0821, 16'h0821);
    // Green difference of one step falls below the floor
    set_config(CfgDataW'(MODE_SUB), 6'd1, 6'd0);
    send_pixel(16'h0020, 16'h0040);
    send_pixel(16'hFFFF, 16'h0001);
    send_pixel(16'h0841, 16'hFFFF);
    set_config(CfgDataW'(MODE_ALPHA), 6'd1, 6'd0);
    send_pixel(16'hFFFF, 16'h0000);
    set_config(CfgDataW'(MODE_ALPHA), 6'd1, CfgDataW'(AlphaMax));
    send_pixel(16'hFFFF, 16'h1234);
    set_config(CfgDataW'(MODE_ALPHA), 6'd1, 6'd16);
    send_pixel(16'hF81F, 16'h07E0);
    set_config(CfgDataW'(MODE_KEEP5), 6'd1, 6'd0);
    send_pixel(16'hFFFF, 16'h1234);
    set_config(CfgDataW'(MODE_KEEP6), 6'd0, 6'd0);
    send_pixel(16'hFFFF, 16'h9234);
    set_config(CfgDataW'(MODE_KEEP7), 6'd1, 6'd0);
    send_pixel(16'h8000, 16'h0001);
    // RGB555: bit 15 passes through copy and is masked elsewhere
    set_config(CfgDataW'(MODE_COPY), 6'd0, 6'd0);
    send_pixel(16'h8001, 16'h0000);
    set_config(CfgDataW'(MODE_AVG), 6'd0, 6'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    set_config(CfgDataW'(MODE_ADD), 6'd0, 6'd0);
    send_pixel(16'h7FFF, 16'h7FFF);
    send_pixel(16'h8000, 16'h8000);
    set_config(CfgDataW'(MODE_SUB), 6'd0, 6'd0);
    send_pixel(16'h0400, 16'h07FF);
    send_pixel(16'h8421, 16'hFFFF);
    set_config(CfgDataW'(MODE_ALPHA), 6'd0, 6'd8);
    send_pixel(16'h7FFF, 16'h8000);
  endtask

  // Alpha clamp, ignored upper data bits and the unused index
  task automatic test_register_writes();
    wait_for_results();
    write_reg(CFG_BLEND_MODE, {3'b101, MODE_ALPHA}, 1'b0);
    write_reg(CFG_FORMAT_565, 6'h3F, 1'b0);
    write_reg(CFG_ALPHA_WEIGHT, 6'd63, 1'b0);
    write_reg(CFG_UNUSED, 6'h3F, 1'b1);
    send_pixel(16'h1234, 16'hABCD);
    wait_for_results();
    write_reg(CFG_FORMAT_565, 6'h3E, 1'b0);
    write_reg(CFG_ALPHA_WEIGHT, 6'd33, 1'b1);
    send_pixel(16'h7C1F, 16'h03E0);
    send_pixel(16'hFFFF, 16'h8421);
  endtask

  // Random settings per phase, random pixels, idling switched per phase
  task automatic test_random_blend();
    logic [PixW-1:0] src;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_for_results();
      tx_gaps_on  <= (phase % 4) != 1;
      rx_stall_on <= (phase % 4) != 2;
      write_reg(CFG_BLEND_MODE, CfgDataW'($urandom), 1'b0);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, CfgDataW'($urandom), 1'b0);
      write_reg(CFG_FORMAT_565, CfgDataW'($urandom), 1'b0);
      write_reg(CFG_ALPHA_WEIGHT, CfgDataW'($urandom), 1'b1);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        src = ($urandom_range(0, 9) == 0) ? '0 : pick_color();
        send_pixel(src, pick_color());
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_blend_modes();
    test_register_writes();
    test_random_blend();
    wait_for_results();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sprite_pixel_blend_565_555.f =====
+incdir+sv
sv/spb_pkg.sv
sv/spb_core.sv
sv/sprite_pixel_blend_565_555.sv
sv/spb_checker.sv
test/tb_sprite_pixel_blend_565_555.sv
